/* design/dbmv_pkg.sv */
// ----------------------------------------------------------------------------
// dbmv_pkg: shared definitions for the down-bar mean volume per trade block
// Widths, default parameter values, the sequencer state type and the structs
// that pass between the sequencer, the divider and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package dbmv_pkg;

  // Default values for the top-level parameters.
  localparam int MAX_SERIES_LEN_DEF = 4096;
  localparam int FRAC_BITS_DEF      = 16;

  // Fixed field and datapath widths.
  localparam int PRICE_W    = 32;
  localparam int VOLUME_W   = 32;
  localparam int TRADES_W   = 32;
  localparam int SUM_W      = 60;
  localparam int MEAN_W     = 48;
  localparam int CNT_W      = 13;
  localparam int CNT_LIMIT  = 8191;
  localparam int DIVIDEND_W = SUM_W;
  localparam int DIVISOR_W  = TRADES_W;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATIO,
    ST_FINISH,
    ST_MEAN,
    ST_OUT
  } state_t;

  // Request to the shared divider.
  typedef struct packed {
    logic                  go;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  // Response from the shared divider.
  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

  // Finished result handed to the output stage.
  typedef struct packed {
    logic              load;
    logic [MEAN_W-1:0] mean;
    logic              ok;
    logic [CNT_W-1:0]  bars;
  } result_t;

endpackage

`default_nettype wire

/* design/dbmv_div.sv */
// ----------------------------------------------------------------------------
// dbmv_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle over the full dividend width.
// A request is taken when idle; done pulses for one cycle with the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module dbmv_div (
  input  logic               clk,
  input  logic               rst,
  input  dbmv_pkg::div_req_t req,
  output dbmv_pkg::div_rsp_t rsp
);
  import dbmv_pkg::*;

  localparam int STEPS  = DIVIDEND_W;
  localparam int STEP_W = $clog2(STEPS);

  logic                  busy;
  logic                  done;
  logic [STEP_W-1:0]     step;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  divisor;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    partial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // One restoring step: bring down the next dividend bit and try to subtract.
  always_comb begin
    partial = {rem, quo[DIVIDEND_W-1]};
    diff    = partial - {1'b0, divisor};
    fits    = partial >= {1'b0, divisor};
  end

  // Step counter and busy/done flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.go && !busy) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  // Remainder and shifting dividend/quotient register.
  always_ff @(posedge clk) begin
    if (req.go && !busy) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[DIVISOR_W-1:0] : partial[DIVISOR_W-1:0];
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

  always_comb begin
    rsp.done     = done;
    rsp.quotient = quo;
  end

`ifndef NO_ASSERTIONS
  a_go_when_idle: assert property (@(posedge clk) disable iff (rst)
    req.go |-> !busy)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a preceding busy cycle");
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    !(done && busy))
    else $error("divider done and busy together");
`endif

endmodule

`default_nettype wire

/* design/dbmv_seq.sv */
// ----------------------------------------------------------------------------
// dbmv_seq: bar sequencer and series accumulator
// Qualifies each bar, drives the shared divider for the per-bar ratio and the
// final mean, keeps the saturating sum and the bar count.
// ----------------------------------------------------------------------------
`default_nettype none

module dbmv_seq #(
  parameter int MAX_SERIES_LEN = dbmv_pkg::MAX_SERIES_LEN_DEF,
  parameter int FRAC_BITS      = dbmv_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          series_start,
  input  logic                          series_end,
  input  logic [dbmv_pkg::PRICE_W-1:0]  bar_price,
  input  logic                          price_ok,
  input  logic [dbmv_pkg::VOLUME_W-1:0] bar_volume,
  input  logic                          volume_ok,
  input  logic [dbmv_pkg::TRADES_W-1:0] trade_count,
  input  logic                          count_ok,
  input  logic                          out_free,
  output dbmv_pkg::div_req_t            req,
  input  dbmv_pkg::div_rsp_t            rsp,
  output dbmv_pkg::result_t             res
);
  import dbmv_pkg::*;

  localparam int CAP_RAW = MAX_SERIES_LEN - 1;
  localparam logic [CNT_W-1:0] COUNT_CAP =
    CNT_W'((CAP_RAW < CNT_LIMIT) ? CAP_RAW : CNT_LIMIT);

  state_t              state;
  state_t              state_next;
  logic [PRICE_W-1:0]  prev_price;
  logic                prev_ok;
  logic [SUM_W-1:0]    sum;
  logic [CNT_W-1:0]    count;
  logic                end_r;
  logic [MEAN_W-1:0]   res_mean;
  logic                res_ok;
  logic                qualify;
  logic [SUM_W:0]      sum_ext;

  // A bar qualifies if valid, not a series start, with trades, under the count cap and below a valid previous price.
  always_comb begin
    qualify = !series_start && prev_ok && price_ok && volume_ok && count_ok &&
              (trade_count != '0) && (bar_price < prev_price) &&
              (count < COUNT_CAP);
    sum_ext = {1'b0, sum} + {1'b0, rsp.quotient};
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, divider requests, handshake and the finished result.
  always_comb begin
    state_next   = state;
    in_stall     = 1'b1;
    req.go       = 1'b0;
    req.dividend = sum;
    req.divisor  = DIVISOR_W'(count);
    res.load     = 1'b0;
    res.mean     = res_mean;
    res.ok       = res_ok;
    res.bars     = count;
    case (state)
      ST_IDLE: begin
        in_stall     = 1'b0;
        req.dividend = DIVIDEND_W'(bar_volume) << FRAC_BITS;
        req.divisor  = trade_count;
        if (in_valid) begin
          if (qualify) begin
            req.go     = 1'b1;
            state_next = ST_RATIO;
          end else if (series_end) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_RATIO: begin
        if (rsp.done) begin
          state_next = end_r ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (count == '0) begin
          state_next = ST_OUT;
        end else begin
          req.go     = 1'b1;
          state_next = ST_MEAN;
        end
      end
      ST_MEAN: begin
        if (rsp.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        res.load = out_free;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Series state: previous price, saturating ratio sum and bar count.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_price <= '0;
      prev_ok    <= 1'b0;
      sum        <= '0;
      count      <= '0;
    end else begin
      if (state == ST_IDLE && in_valid) begin
        if (series_start) begin
          sum   <= '0;
          count <= '0;
        end
        prev_price <= bar_price;
        prev_ok    <= price_ok;
      end
      if (state == ST_RATIO && rsp.done) begin
        sum   <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
        count <= count + 1'b1;
      end
      if (state == ST_OUT && out_free) begin
        sum     <= '0;
        count   <= '0;
        prev_ok <= 1'b0;
      end
    end
  end

  // End flag of the bar in flight and the finished mean.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      end_r <= series_end;
    end
    if (state == ST_FINISH && count == '0) begin
      res_mean <= '0;
      res_ok   <= 1'b0;
    end
    if (state == ST_MEAN && rsp.done) begin
      res_mean <= (|rsp.quotient[DIVIDEND_W-1:MEAN_W]) ? '1 : rsp.quotient[MEAN_W-1:0];
      res_ok   <= 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_capped: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_CAP)
    else $error("bar count beyond its cap");
  a_go_states: assert property (@(posedge clk) disable iff (rst)
    req.go |-> (state == ST_IDLE || state == ST_FINISH))
    else $error("divider started from a wrong state");
  a_done_states: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == ST_RATIO || state == ST_MEAN))
    else $error("divider result arrived in a wrong state");
`endif

endmodule

`default_nettype wire

/* design/down_bar_mean_volume_per_trade.sv */
// ----------------------------------------------------------------------------
// down_bar_mean_volume_per_trade: mean volume per trade over falling bars
// Top level: bar sequencer, shared iterative divider and the result register.
// ----------------------------------------------------------------------------
// A bar that does not qualify as a down bar is taken as soon as the sequencer
// is idle. A down bar runs a 60-step restoring division (volume scaled by the
// fraction bits over the trade count) on the single shared divider, and the
// next beat is not taken until that ratio is added to the sum. On the last
// bar of a series the same divider forms the mean before the result beat
// appears; the result waits in its own register, so input beats keep flowing
// while it is stalled, unless the next series ends before it is taken.
`default_nettype none

module down_bar_mean_volume_per_trade #(
  parameter int MAX_SERIES_LEN = dbmv_pkg::MAX_SERIES_LEN_DEF,
  parameter int FRAC_BITS      = dbmv_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          series_start,
  input  logic                          series_end,
  input  logic [dbmv_pkg::PRICE_W-1:0]  bar_price,
  input  logic                          price_ok,
  input  logic [dbmv_pkg::VOLUME_W-1:0] bar_volume,
  input  logic                          volume_ok,
  input  logic [dbmv_pkg::TRADES_W-1:0] trade_count,
  input  logic                          count_ok,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dbmv_pkg::MEAN_W-1:0]   mean_per_trade,
  output logic                          mean_valid,
  output logic [dbmv_pkg::CNT_W-1:0]    down_bars
);
  import dbmv_pkg::*;

  div_req_t req;
  div_rsp_t rsp;
  result_t  res;
  logic     out_free;

  dbmv_seq #(
    .MAX_SERIES_LEN(MAX_SERIES_LEN),
    .FRAC_BITS     (FRAC_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .series_start(series_start),
    .series_end  (series_end),
    .bar_price   (bar_price),
    .price_ok    (price_ok),
    .bar_volume  (bar_volume),
    .volume_ok   (volume_ok),
    .trade_count (trade_count),
    .count_ok    (count_ok),
    .out_free    (out_free),
    .req         (req),
    .rsp         (rsp),
    .res         (res)
  );

  dbmv_div u_div (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // The result register is free when empty or when its beat leaves this cycle.
  assign out_free = !out_valid || !out_stall;

  // Result beat valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result beat payload.
  always_ff @(posedge clk) begin
    if (res.load) begin
      mean_per_trade <= res.mean;
      mean_valid     <= res.ok;
      down_bars      <= res.bars;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    res.load |-> out_free)
    else $error("result loaded over a stalled beat");
  a_stall_while_loading: assert property (@(posedge clk) disable iff (rst)
    res.load |-> in_stall)
    else $error("input taken while a result is being loaded");
  a_invalid_means_empty: assert property (@(posedge clk) disable iff (rst)
    (res.load && !res.ok) |-> (res.bars == '0))
    else $error("empty result reports down bars");
`endif

endmodule

`default_nettype wire
